// ===== rtl/core/rnsbc_pkg.sv =====
`default_nettype none
package rnsbc_pkg;
    localparam int WORD_BITS = 64;
    localparam int NUM_SRC = 16;
    localparam int NUM_TGT = 16;
    localparam int IDX_BITS = 4;
    localparam int CNT_BITS = 5;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_BITS-1:0] idx_t;

    typedef enum logic [1:0] {
        CMD_LOAD_SOURCE = 2'd0,
        CMD_LOAD_TARGET = 2'd1,
        CMD_LOAD_WEIGHT = 2'd2,
        CMD_RESIDUE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SOURCE_LIMBS  = 2'd0,
        REG_TARGET_LIMBS  = 2'd1,
        REG_GROUP_SIZE    = 2'd2,
        REG_PLAIN_MODULUS = 2'd3
    } reg_idx_t;

    // modular multiply request/response between sequencer and unit
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t r;
    } mm_rsp_t;

    // a + b mod m with a, b already below m (m != 0)
    function automatic word_t add_mod_red(word_t a, word_t b, word_t m);
        logic [WORD_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, m}) s = s - {1'b0, m};
            add_mod_red = s[WORD_BITS-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rnsbc_ram.sv =====
`default_nettype none
module rnsbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/rnsbc_modunit.sv =====
`default_nettype none
// Shared unit: bit-serial double-and-add modular multiply, plus a
// restoring reduction a mod m, one bit per cycle.
module rnsbc_modunit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             red_only,
    input  rnsbc_pkg::mm_req_t    req,
    output rnsbc_pkg::mm_rsp_t    rsp
);
    import rnsbc_pkg::*;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_RA   = 4'b0010,
        U_RB   = 4'b0100,
        U_MUL  = 4'b1000
    } ustate_t;

    ustate_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    word_t a_reg, a_next, b_reg, b_next, m_reg, m_next, r_reg, r_next;
    word_t rem_reg, rem_next;
    logic  ro_reg, ro_next;
    logic  done_reg, done_next;
    logic [WORD_BITS:0] trial;

    // restoring reduction step: shift in next bit of a_reg
    always_comb begin
        trial = {rem_reg, a_reg[WORD_BITS-1]};
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        m_next = m_reg;
        r_next = r_reg;
        rem_next = rem_reg;
        ro_next = ro_reg;
        done_next = 1'b0;
        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    a_next = req.a;
                    b_next = req.b;
                    m_next = req.m;
                    ro_next = red_only;
                    rem_next = '0;
                    cnt_next = 7'(WORD_BITS);
                    if (req.m == '0) begin
                        r_next = '0;
                        done_next = 1'b1;
                    end else begin
                        state_next = U_RA;
                    end
                end
            end
            U_RA, U_RB: begin
                if (trial >= {1'b0, m_reg}) begin
                    rem_next = WORD_BITS'(trial - {1'b0, m_reg});
                end else begin
                    rem_next = trial[WORD_BITS-1:0];
                end
                a_next = {a_reg[WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    cnt_next = 7'(WORD_BITS);
                    if (state_reg == U_RA) begin
                        if (ro_reg) begin
                            r_next = rem_next;
                            done_next = 1'b1;
                            state_next = U_IDLE;
                        end else begin
                            // keep a mod m in r_reg, reduce b next
                            r_next = rem_next;
                            a_next = b_reg;
                            rem_next = '0;
                            state_next = U_RB;
                        end
                    end else begin
                        a_next = r_reg;
                        b_next = rem_next;
                        r_next = '0;
                        state_next = U_MUL;
                    end
                end
            end
            U_MUL: begin
                r_next = add_mod_red(r_reg, r_reg, m_reg);
                if (b_reg[WORD_BITS-1]) r_next = add_mod_red(r_next, a_reg, m_reg);
                b_next = {b_reg[WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    done_next = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
        rem_reg <= rem_next;
        ro_reg <= ro_next;
    end

    assign rsp.done = done_reg;
    assign rsp.r = r_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rns_base_conversion_unit.sv =====
`default_nettype none
// Load items are taken while idle and the input stays ready, so loads go back to back.
// A residue item is first scaled, then handled per target: reduce, multiply, reduce acc;
// a zero scale skips both. An emit adds a pass per target, and its steps differ by mode.
// A zero modulus skips the shared unit's reduction and yields zero.
// Throughput: one item at a time; s_tready is low while a residue is in work or a result waits.
// Reset: aresetn synchronous, active low; clears control, registers, accumulators, residues.
module rns_base_conversion_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] command, [5:2] source_index, [9:6] target_index,
    // [73:10] word_a, [137:74] word_b, [143:138] zero
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [3:0] group_number, [7:4] target_number, [71:8] converted_value
    output logic [71:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import rnsbc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_RD      = 13'b0000000000010,
        S_SCALE   = 13'b0000000000100,
        S_TRD     = 13'b0000000001000,
        S_TRED    = 13'b0000000010000,
        S_TMUL    = 13'b0000000100000,
        S_EMRD    = 13'b0000001000000,
        S_EMRED   = 13'b0000010000000,
        S_EMT     = 13'b0000100000000,
        S_EMINV   = 13'b0001000000000,
        S_OUT     = 13'b0010000000000,
        S_WAITW   = 13'b0100000000000,
        S_TACC    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // config
    logic [CNT_BITS-1:0] ns_reg, nt_reg, gs_reg;
    word_t pm_reg;
    assign cfg_ready = 1'b1;

    logic [CNT_BITS-1:0] ns_eff, nt_eff, g_eff;
    always_comb begin
        ns_eff = (ns_reg == '0) ? CNT_BITS'(1) : (ns_reg > CNT_BITS'(NUM_SRC) ?
                 CNT_BITS'(NUM_SRC) : ns_reg);
        nt_eff = (nt_reg == '0) ? CNT_BITS'(1) : (nt_reg > CNT_BITS'(NUM_TGT) ?
                 CNT_BITS'(NUM_TGT) : nt_reg);
        g_eff  = (gs_reg == '0) ? CNT_BITS'(1) : gs_reg;
    end

    // input fields
    logic [1:0] in_cmd;
    idx_t in_si, in_ti;
    word_t in_wa, in_wb;
    assign in_cmd = s_tdata[1:0];
    assign in_si  = s_tdata[5:2];
    assign in_ti  = s_tdata[9:6];
    assign in_wa  = s_tdata[73:10];
    assign in_wb  = s_tdata[137:74];

    logic s_fire;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire = s_tvalid && s_tready;

    logic residue_ok;
    assign residue_ok = (in_cmd == CMD_RESIDUE) && ({1'b0, in_si} < ns_eff);

    // small tables in flops (read at the current index only)
    word_t prime_reg [NUM_SRC];
    word_t scale_reg [NUM_SRC];
    word_t tmod_reg [NUM_TGT];
    word_t tinv_reg [NUM_TGT];
    idx_t  rlimb_reg [NUM_TGT];
    word_t acc_reg [NUM_TGT];
    word_t rres_reg [NUM_SRC];

    // weights in RAM
    logic we;
    logic [7:0] waddr, raddr;
    word_t wdata;
    assign we = s_fire && (in_cmd == CMD_LOAD_WEIGHT);
    assign waddr = {in_si, in_ti};
    assign wdata = in_wa;

    // work registers
    idx_t si_reg;
    idx_t t_reg, t_next;
    word_t res_reg;
    word_t u_reg, u_next;
    word_t c_reg, c_next;
    word_t v_reg, v_next;
    word_t w_rdata;
    logic emit_reg;
    logic [3:0] grp_reg;
    logic [71:0] out_data_reg;
    logic out_last_reg;
    logic out_valid_reg;

    assign raddr = {si_reg, t_reg};

    rnsbc_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_SRC * NUM_TGT)) u_wram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (w_rdata)
    );

    // shared unit
    mm_req_t mm_req;
    mm_rsp_t mm_rsp;
    logic red_only;
    logic mm_busy_reg, mm_busy_next;

    rnsbc_modunit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .red_only (red_only),
        .req      (mm_req),
        .rsp      (mm_rsp)
    );

    word_t p_cur, q_cur;
    logic low;
    word_t mag;
    assign p_cur = prime_reg[si_reg];
    assign q_cur = tmod_reg[t_reg];
    assign low = (u_reg <= {1'b0, p_cur[WORD_BITS-1:1]});
    assign mag = mm_rsp.r;

    logic last_limb;
    logic [CNT_BITS-1:0] si_ext;
    assign si_ext = {1'b0, si_reg};
    assign last_limb = (si_ext == ns_eff - CNT_BITS'(1));

    // group index si / g and boundary (si+1) % g == 0: si < 16, so compare
    // si+1 against the first sixteen multiples of g
    logic [3:0] grp_q;
    logic grp_end_div;
    always_comb begin
        logic [9:0] mult;
        grp_q = '0;
        grp_end_div = last_limb;
        for (int k = 1; k <= NUM_SRC; k++) begin
            mult = 10'(k) * {5'b0, g_eff};
            if ({5'b0, si_ext} + 10'd1 == mult) grp_end_div = 1'b1;
            if ({5'b0, si_ext} >= mult) grp_q = grp_q + 4'd1;
        end
    end

    logic emit_now;
    assign emit_now = (pm_reg != '0) ? last_limb : grp_end_div;

    word_t r_ret;
    assign r_ret = rres_reg[rlimb_reg[t_reg]];

    logic mm_go;
    logic is_last_t;
    assign is_last_t = ({1'b0, t_reg} == nt_eff - CNT_BITS'(1));

    // result register takes the next item once the previous one is gone
    logic out_load;
    assign out_load = (state_reg == S_WAITW) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        t_next = t_reg;
        u_next = u_reg;
        c_next = c_reg;
        v_next = v_reg;
        mm_req = '0;
        red_only = 1'b0;
        mm_busy_next = mm_busy_reg;
        mm_go = !mm_busy_reg;
        case (state_reg)
            S_IDLE: begin
                t_next = '0;
                if (s_fire && residue_ok) state_next = S_RD;
            end
            S_RD: begin
                if (scale_reg[si_reg] == '0) begin
                    state_next = emit_now ? S_EMRD : S_IDLE;
                    t_next = '0;
                end else begin
                    mm_req.start = mm_go;
                    mm_req.a = res_reg;
                    mm_req.b = scale_reg[si_reg];
                    mm_req.m = p_cur;
                    if (mm_go) mm_busy_next = 1'b1;
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                if (mm_rsp.done) begin
                    u_next = mm_rsp.r;
                    mm_busy_next = 1'b0;
                    t_next = '0;
                    state_next = S_TRD;
                end
            end
            S_TRD: begin
                // magnitude mod q
                mm_req.start = 1'b1;
                red_only = 1'b1;
                mm_req.a = low ? u_reg : p_cur - u_reg;
                mm_req.m = q_cur;
                state_next = S_TRED;
            end
            S_TRED: begin
                if (mm_rsp.done) begin
                    state_next = S_TMUL;
                    mm_req.start = 1'b1;
                    mm_req.a = (low || mag == '0) ? mag : q_cur - mag;
                    mm_req.b = w_rdata;
                    mm_req.m = q_cur;
                end
            end
            S_TMUL: begin
                // keep the product, then bring the accumulator below q
                if (mm_rsp.done) begin
                    c_next = mm_rsp.r;
                    red_only = 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.a = acc_reg[t_reg];
                    mm_req.m = q_cur;
                    state_next = S_TACC;
                end
            end
            S_TACC: begin
                if (mm_rsp.done) begin
                    v_next = (q_cur == '0) ? '0 : add_mod_red(mm_rsp.r, c_reg, q_cur);
                    if (is_last_t) begin
                        t_next = '0;
                        state_next = emit_reg ? S_EMRD : S_IDLE;
                    end else begin
                        t_next = t_reg + idx_t'(1);
                        state_next = S_TRD;
                    end
                end
            end
            S_EMRD: begin
                if (pm_reg == '0) begin
                    red_only = 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.a = acc_reg[t_reg];
                    mm_req.m = q_cur;
                    state_next = S_EMINV;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a = acc_reg[t_reg];
                    mm_req.b = pm_reg;
                    mm_req.m = q_cur;
                    state_next = S_EMRED;
                end
            end
            S_EMRED: begin
                if (mm_rsp.done) begin
                    v_next = mm_rsp.r;
                    red_only = 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.a = r_ret;
                    mm_req.m = q_cur;
                    state_next = S_EMT;
                end
            end
            S_EMT: begin
                if (mm_rsp.done) begin
                    mm_req.start = 1'b1;
                    mm_req.a = (q_cur == '0) ? '0 : add_mod_red(v_reg, mm_rsp.r, q_cur);
                    mm_req.b = tinv_reg[t_reg];
                    mm_req.m = q_cur;
                    state_next = S_EMINV;
                end
            end
            S_EMINV: begin
                if (mm_rsp.done) begin
                    v_next = mm_rsp.r;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                state_next = S_WAITW;
            end
            S_WAITW: begin
                if (out_load) begin
                    if (is_last_t) begin
                        state_next = S_IDLE;
                    end else begin
                        t_next = t_reg + idx_t'(1);
                        state_next = S_EMRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ns_reg <= CNT_BITS'(1);
            nt_reg <= CNT_BITS'(1);
            gs_reg <= CNT_BITS'(1);
            pm_reg <= '0;
            out_valid_reg <= 1'b0;
            mm_busy_reg <= 1'b0;
            for (int i = 0; i < NUM_TGT; i++) acc_reg[i] <= '0;
            for (int i = 0; i < NUM_SRC; i++) rres_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            mm_busy_reg <= mm_busy_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SOURCE_LIMBS:  ns_reg <= cfg_data[CNT_BITS-1:0];
                    REG_TARGET_LIMBS:  nt_reg <= cfg_data[CNT_BITS-1:0];
                    REG_GROUP_SIZE:    gs_reg <= cfg_data[CNT_BITS-1:0];
                    REG_PLAIN_MODULUS: pm_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_fire && residue_ok) begin
                rres_reg[in_si] <= in_wa;
            end
            if (state_reg == S_TACC && mm_rsp.done) acc_reg[t_reg] <= v_next;
            if (out_load && is_last_t) begin
                for (int i = 0; i < NUM_TGT; i++) acc_reg[i] <= '0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            case (in_cmd)
                CMD_LOAD_SOURCE: begin
                    prime_reg[in_si] <= in_wa;
                    scale_reg[in_si] <= in_wb;
                end
                CMD_LOAD_TARGET: begin
                    tmod_reg[in_ti] <= in_wa;
                    tinv_reg[in_ti] <= in_wb;
                    rlimb_reg[in_ti] <= in_si;
                end
                default: ;
            endcase
        end
        t_reg <= t_next;
        u_reg <= u_next;
        c_reg <= c_next;
        v_reg <= v_next;
        if (s_fire) begin
            si_reg <= in_si;
            res_reg <= in_wa;
        end
        if (state_reg == S_RD) begin
            emit_reg <= emit_now;
            grp_reg <= (pm_reg != '0) ? 4'd0 : grp_q;
        end
        if (out_load) begin
            out_data_reg <= {(q_cur == '0) ? word_t'(0) : v_reg, t_reg, grp_reg};
            out_last_reg <= is_last_t;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rnsbc_checker.sv =====
`default_nettype none
module rnsbc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata,
    input wire logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output item raised while input was open");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tready, m_tvalid}))
        else $error("handshake signal unknown");
endmodule
bind rns_base_conversion_unit rnsbc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
